FILE: hdl/c6502_pkg.sv
// Package for the 6502 bus core: micro-step codes, addressing modes,
// access kinds, the decoded-class record and the front-to-back queue entry.
// No dependencies.
package c6502_pkg;

  localparam logic [3:0] ST_VLO    = 4'd0;
  localparam logic [3:0] ST_VHI    = 4'd1;
  localparam logic [3:0] ST_OP     = 4'd2;
  localparam logic [3:0] ST_OPD1   = 4'd3;
  localparam logic [3:0] ST_OPD2   = 4'd4;
  localparam logic [3:0] ST_PTR_LO = 4'd5;
  localparam logic [3:0] ST_PTR_HI = 4'd6;
  localparam logic [3:0] ST_DATA   = 4'd7;
  localparam logic [3:0] ST_PULL1  = 4'd8;
  localparam logic [3:0] ST_PULL2  = 4'd9;
  localparam logic [3:0] ST_PULL3  = 4'd10;

  typedef enum logic [4:0] {
    M_IMP, M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABX, M_ABY, M_IZX, M_IZY,
    M_REL, M_BRK, M_JSR, M_RTI, M_RTS, M_PHA, M_PHP, M_PLA, M_PLP, M_JMP, M_JMPI
  } mode_e;

  typedef enum logic [1:0] {K_READ, K_RMW, K_STORE} kind_e;

  typedef struct packed {
    mode_e mode;
    kind_e kind;
  } cls_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       nmi_request;
  } item_t;

  // One bus access as it leaves the core.
  typedef struct packed {
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic        is_write;
    logic        fetch;
    logic        last;
  } acc_t;

  localparam logic [15:0] VEC_RESET = 16'hFFFC;
  localparam logic [15:0] VEC_BRK   = 16'hFFFE;
  localparam logic [15:0] VEC_NMI   = 16'hFFFA;
  localparam logic [7:0]  FLAGS_RST = 8'h24;
  localparam logic [7:0]  SP_RST    = 8'hFD;
  localparam int          QDEPTH    = 2;
  localparam int          MAXRES    = 4;

  function automatic cls_t classify(input logic [7:0] op);
    logic [1:0] cc;
    logic [2:0] bbb;
    logic [2:0] aaa;
    kind_e k2;
    kind_e k0;
    cls_t r;
    cc  = op[1:0];
    bbb = op[4:2];
    aaa = op[7:5];
    k2 = (aaa == 3'd4) ? K_STORE : (aaa == 3'd5) ? K_READ : K_RMW;
    k0 = (aaa == 3'd4) ? K_STORE : K_READ;
    r.mode = M_IMP;
    r.kind = K_READ;
    if (cc == 2'd1) begin
      if (op != 8'h89) begin
        r.kind = (aaa == 3'd4) ? K_STORE : K_READ;
        case (bbb)
          3'd0: r.mode = M_IZX;
          3'd1: r.mode = M_ZP;
          3'd2: r.mode = M_IMM;
          3'd3: r.mode = M_ABS;
          3'd4: r.mode = M_IZY;
          3'd5: r.mode = M_ZPX;
          3'd6: r.mode = M_ABY;
          default: r.mode = M_ABX;
        endcase
      end
    end else if (cc == 2'd2) begin
      case (bbb)
        3'd0: if (op == 8'hA2) r.mode = M_IMM;
        3'd1: begin r.mode = M_ZP; r.kind = k2; end
        3'd3: begin r.mode = M_ABS; r.kind = k2; end
        3'd5: begin
          r.mode = (aaa == 3'd4 || aaa == 3'd5) ? M_ZPY : M_ZPX;
          r.kind = k2;
        end
        3'd7: begin
          if (aaa == 3'd5) r.mode = M_ABY;
          else if (aaa != 3'd4) begin r.mode = M_ABX; r.kind = K_RMW; end
        end
        default: r.mode = M_IMP;
      endcase
    end else if (cc == 2'd0) begin
      case (bbb)
        3'd0: begin
          case (aaa)
            3'd0: r.mode = M_BRK;
            3'd1: r.mode = M_JSR;
            3'd2: r.mode = M_RTI;
            3'd3: r.mode = M_RTS;
            3'd4: r.mode = M_IMP;
            default: r.mode = M_IMM;
          endcase
        end
        3'd1: if (!(aaa == 3'd0 || aaa == 3'd2 || aaa == 3'd3)) begin
          r.mode = M_ZP; r.kind = k0;
        end
        3'd2: begin
          case (aaa)
            3'd0: r.mode = M_PHP;
            3'd1: r.mode = M_PLP;
            3'd2: r.mode = M_PHA;
            3'd3: r.mode = M_PLA;
            default: r.mode = M_IMP;
          endcase
        end
        3'd3: begin
          if (aaa == 3'd2) r.mode = M_JMP;
          else if (aaa == 3'd3) r.mode = M_JMPI;
          else if (aaa != 3'd0) begin r.mode = M_ABS; r.kind = k0; end
        end
        3'd4: r.mode = M_REL;
        3'd5: if (aaa == 3'd4 || aaa == 3'd5) begin r.mode = M_ZPX; r.kind = k0; end
        3'd7: if (aaa == 3'd5) r.mode = M_ABX;
        default: r.mode = M_IMP;
      endcase
    end
    return r;
  endfunction

endpackage

FILE: hdl/c6502_front.sv
// Front end: takes bus responses, stalls only when the queue is full.
// Depends on c6502_pkg.
module c6502_front import c6502_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] read_data_i,
  input  logic       nmi_request_i,
  output logic       q_valid_o,
  input  logic       q_pop_i,
  output item_t      q_head_o
);
  item_t      buf_q [QDEPTH];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  assign in_stall_o = (cnt_q == 2'(QDEPTH));
  assign push = in_valid_i && !in_stall_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_head_o = buf_q[rp_q];

  always_comb begin
    wp_d = wp_q + 1'(push);
    rp_d = rp_q + 1'(q_pop_i && q_valid_o);
    cnt_d = cnt_q + 2'(push) - 2'(q_pop_i && q_valid_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q <= wp_d;
      rp_q <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wp_q].read_data <= read_data_i;
      buf_q[wp_q].nmi_request <= nmi_request_i;
    end
  end
endmodule

FILE: hdl/c6502_back.sv
// Back end: executes one queued response per step and streams its accesses
// through a registered output slot. Depends on c6502_pkg.
module c6502_back import c6502_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  output logic        q_pop_o,
  input  item_t       q_head_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output acc_t        out_o
);
  logic [7:0]  a_q, a_d, x_q, x_d, y_q, y_d, p_q, p_d, s_q, s_d;
  logic [15:0] pc_q, pc_d, al_q, al_d;
  logic [7:0]  op_q, op_d, dl_q, dl_d;
  logic [3:0]  st_q, st_d;

  acc_t        acc_q [MAXRES];
  acc_t        acc_d [MAXRES];
  logic [2:0]  n_q, n_d;
  logic [1:0]  idx_q;
  logic [2:0]  n;
  logic        busy;
  logic        slot_free;

  assign busy = (n_q != 3'd0);
  assign out_valid_o = busy;
  assign out_o = acc_q[idx_q];
  assign slot_free = !busy || (!out_stall_i && idx_q == 2'(n_q - 3'd1));
  assign q_pop_o = q_valid_i && slot_free;

  function automatic logic [7:0] nz(input logic [7:0] f, input logic [7:0] v);
    return (f & 8'h7D) | (v & 8'h80) | ((v == 8'd0) ? 8'h02 : 8'h00);
  endfunction

  always_comb begin
    logic [7:0] b, v, r, sub, st8;
    logic [8:0] sum;
    logic       c;
    cls_t       cl, cln;
    logic [15:0] base, addr, off;
    logic [2:0] aaa;
    logic       do_acc, take;
    logic [1:0] cc;
    logic [7:0] pushed;
    logic       brk, irq;
    a_d = a_q; x_d = x_q; y_d = y_q; p_d = p_q; s_d = s_q;
    pc_d = pc_q; al_d = al_q; op_d = op_q; dl_d = dl_q; st_d = st_q;
    for (int i = 0; i < MAXRES; i++) acc_d[i] = '0;
    n = 3'd0;
    b = q_head_i.read_data;
    cl = classify(op_q);
    base = {b, dl_q};
    addr = 16'd0;
    do_acc = 1'b0;
    v = 8'd0; r = 8'd0; sum = 9'd0; sub = 8'd0; st8 = 8'd0; c = 1'b0;
    off = 16'd0; aaa = op_q[7:5]; cc = op_q[1:0]; take = 1'b0;
    cln = classify(b);
    pushed = 8'd0;
    brk = 1'b0; irq = 1'b0;

    case (st_q)
      ST_VLO: begin
        dl_d = b;
        acc_d[0] = '{addr: al_q + 16'd1, wdata: 8'd0, is_write: 1'b0, fetch: 1'b0,
                     last: 1'b1};
        n = 3'd1; st_d = ST_VHI;
      end
      ST_VHI: begin pc_d = base; end
      ST_OP: begin
        if (q_head_i.nmi_request) begin
          irq = 1'b1;
          pushed = (p_q & 8'hEF) | 8'h20;
        end else begin
          op_d = b;
          pc_d = pc_q + 16'd1;
          case (cln.mode)
            M_IMP: begin
              case (b)
                8'h0A: begin p_d = {p_q[7:1], a_q[7]}; a_d = {a_q[6:0], 1'b0}; end
                8'h2A: begin p_d = {p_q[7:1], a_q[7]}; a_d = {a_q[6:0], p_q[0]}; end
                8'h4A: begin p_d = {p_q[7:1], a_q[0]}; a_d = {1'b0, a_q[7:1]}; end
                8'h6A: begin p_d = {p_q[7:1], a_q[0]}; a_d = {p_q[0], a_q[7:1]}; end
                8'h18: p_d = p_q & 8'hFE;
                8'h38: p_d = p_q | 8'h01;
                8'h58: p_d = p_q & 8'hFB;
                8'h78: p_d = p_q | 8'h04;
                8'hB8: p_d = p_q & 8'hBF;
                8'hD8: p_d = p_q & 8'hF7;
                8'hF8: p_d = p_q | 8'h08;
                8'hAA: x_d = a_q;
                8'hA8: y_d = a_q;
                8'hBA: x_d = s_q;
                8'h8A: a_d = x_q;
                8'h9A: s_d = x_q;
                8'h98: a_d = y_q;
                8'hE8: x_d = x_q + 8'd1;
                8'hC8: y_d = y_q + 8'd1;
                8'hCA: x_d = x_q - 8'd1;
                8'h88: y_d = y_q - 8'd1;
                default: ;
              endcase
              case (b)
                8'h0A, 8'h2A, 8'h4A, 8'h6A, 8'h8A, 8'h98: p_d = nz(p_d, a_d);
                8'hAA, 8'hBA, 8'hE8, 8'hCA: p_d = nz(p_d, x_d);
                8'hA8, 8'hC8, 8'h88: p_d = nz(p_d, y_d);
                default: ;
              endcase
            end
            M_PHA: begin
              acc_d[0] = '{addr: {8'h01, s_q}, wdata: a_q, is_write: 1'b1, fetch: 1'b0,
                           last: 1'b0};
              n = 3'd1; s_d = s_q - 8'd1;
            end
            M_PHP: begin
              acc_d[0] = '{addr: {8'h01, s_q}, wdata: p_q | 8'h30, is_write: 1'b1,
                           fetch: 1'b0, last: 1'b0};
              n = 3'd1; s_d = s_q - 8'd1;
            end
            M_PLA, M_PLP, M_RTS, M_RTI: begin
              s_d = s_q + 8'd1;
              acc_d[0] = '{addr: {8'h01, s_d}, wdata: 8'd0, is_write: 1'b0, fetch: 1'b0,
                           last: 1'b1};
              n = 3'd1; st_d = ST_PULL1;
            end
            M_BRK: begin
              brk = 1'b1; irq = 1'b1;
              pushed = p_q | 8'h30;
            end
            default: begin
              acc_d[0] = '{addr: pc_q + 16'd1, wdata: 8'd0, is_write: 1'b0,
                           fetch: 1'b0, last: 1'b1};
              pc_d = pc_q + 16'd2;
              n = 3'd1; st_d = ST_OPD1;
            end
          endcase
        end
      end
      ST_OPD1: begin
        case (cl.mode)
          M_IMM: begin v = b; take = 1'b1; end
          M_REL: begin
            case (aaa[2:1])
              2'd0: c = p_q[7];
              2'd1: c = p_q[6];
              2'd2: c = p_q[0];
              default: c = p_q[1];
            endcase
            if (c == aaa[0]) begin
              off = {{8{b[7]}}, b};
              pc_d = pc_q + off;
            end
          end
          M_ZP:  begin addr = {8'd0, b}; do_acc = 1'b1; end
          M_ZPX: begin addr = {8'd0, b + x_q}; do_acc = 1'b1; end
          M_ZPY: begin addr = {8'd0, b + y_q}; do_acc = 1'b1; end
          M_IZX, M_IZY: begin
            al_d = (cl.mode == M_IZX) ? {8'd0, b + x_q} : {8'd0, b};
            acc_d[0] = '{addr: al_d, wdata: 8'd0, is_write: 1'b0, fetch: 1'b0, last: 1'b1};
            n = 3'd1; st_d = ST_PTR_LO;
          end
          M_JSR: begin
            dl_d = b;
            acc_d[0] = '{addr: {8'h01, s_q}, wdata: pc_q[15:8], is_write: 1'b1,
                         fetch: 1'b0, last: 1'b0};
            acc_d[1] = '{addr: {8'h01, s_q - 8'd1}, wdata: pc_q[7:0], is_write: 1'b1,
                         fetch: 1'b0, last: 1'b0};
            acc_d[2] = '{addr: pc_q, wdata: 8'd0, is_write: 1'b0, fetch: 1'b0, last: 1'b1};
            s_d = s_q - 8'd2;
            n = 3'd3; st_d = ST_OPD2;
          end
          default: begin
            dl_d = b;
            acc_d[0] = '{addr: pc_q, wdata: 8'd0, is_write: 1'b0, fetch: 1'b0, last: 1'b1};
            pc_d = pc_q + 16'd1;
            n = 3'd1; st_d = ST_OPD2;
          end
        endcase
      end
      ST_OPD2: begin
        case (cl.mode)
          M_JSR, M_JMP: pc_d = base;
          M_JMPI: begin
            al_d = base;
            acc_d[0] = '{addr: base, wdata: 8'd0, is_write: 1'b0, fetch: 1'b0, last: 1'b1};
            n = 3'd1; st_d = ST_PTR_LO;
          end
          M_ABS: begin addr = base; do_acc = 1'b1; end
          M_ABX: begin addr = base + {8'd0, x_q}; do_acc = 1'b1; end
          M_ABY: begin addr = base + {8'd0, y_q}; do_acc = 1'b1; end
          default: ;
        endcase
      end
      ST_PTR_LO: begin
        dl_d = b;
        if (cl.mode == M_JMPI) addr = {al_q[15:8], al_q[7:0] + 8'd1};
        else addr = {8'd0, al_q[7:0] + 8'd1};
        acc_d[0] = '{addr: addr, wdata: 8'd0, is_write: 1'b0, fetch: 1'b0, last: 1'b1};
        n = 3'd1; st_d = ST_PTR_HI;
      end
      ST_PTR_HI: begin
        if (cl.mode == M_JMPI) pc_d = base;
        else begin
          addr = (cl.mode == M_IZY) ? base + {8'd0, y_q} : base;
          do_acc = 1'b1;
        end
      end
      ST_DATA: begin
        if (cl.kind == K_RMW) begin
          r = b;
          case (aaa)
            3'd0: begin c = b[7]; r = {b[6:0], 1'b0}; end
            3'd1: begin c = b[7]; r = {b[6:0], p_q[0]}; end
            3'd2: begin c = b[0]; r = {1'b0, b[7:1]}; end
            3'd3: begin c = b[0]; r = {p_q[0], b[7:1]}; end
            3'd6: begin c = p_q[0]; r = b - 8'd1; end
            3'd7: begin c = p_q[0]; r = b + 8'd1; end
            default: c = p_q[0];
          endcase
          p_d = nz({p_q[7:1], c}, r);
          acc_d[0] = '{addr: al_q, wdata: b, is_write: 1'b1, fetch: 1'b0, last: 1'b0};
          acc_d[1] = '{addr: al_q, wdata: r, is_write: 1'b1, fetch: 1'b0, last: 1'b0};
          n = 3'd2;
        end else begin
          v = b; take = 1'b1;
        end
      end
      ST_PULL1: begin
        if (cl.mode == M_PLA) begin a_d = b; p_d = nz(p_q, b); end
        else if (cl.mode == M_PLP) p_d = (b & 8'hEF) | 8'h20;
        else begin
          if (cl.mode == M_RTI) p_d = (b & 8'hEF) | 8'h20;
          else dl_d = b;
          s_d = s_q + 8'd1;
          acc_d[0] = '{addr: {8'h01, s_d}, wdata: 8'd0, is_write: 1'b0, fetch: 1'b0,
                       last: 1'b1};
          n = 3'd1; st_d = ST_PULL2;
        end
      end
      ST_PULL2: begin
        if (cl.mode == M_RTI) begin
          dl_d = b; s_d = s_q + 8'd1;
          acc_d[0] = '{addr: {8'h01, s_d}, wdata: 8'd0, is_write: 1'b0, fetch: 1'b0,
                       last: 1'b1};
          n = 3'd1; st_d = ST_PULL3;
        end else pc_d = base + 16'd1;
      end
      ST_PULL3: pc_d = base;
      default: ;
    endcase

    // Operand consumers shared by immediate and memory read forms.
    if (take) begin
      if (cc == 2'd1) begin
        case (aaa)
          3'd0: begin a_d = a_q | v; p_d = nz(p_q, a_d); end
          3'd1: begin a_d = a_q & v; p_d = nz(p_q, a_d); end
          3'd2: begin a_d = a_q ^ v; p_d = nz(p_q, a_d); end
          3'd3, 3'd7: begin
            sub = (aaa == 3'd7) ? ~v : v;
            sum = {1'b0, a_q} + {1'b0, sub} + {8'd0, p_q[0]};
            st8 = p_q & 8'hBE;
            st8[0] = sum[8];
            st8[6] = (a_q[7] ^ sum[7]) & (sub[7] ^ sum[7]);
            a_d = sum[7:0];
            p_d = nz(st8, sum[7:0]);
          end
          3'd5: begin a_d = v; p_d = nz(p_q, v); end
          3'd6: begin
            sum = {1'b0, a_q} - {1'b0, v};
            p_d = nz(p_q, sum[7:0]); p_d[0] = !sum[8];
          end
          default: ;
        endcase
      end else if (cc == 2'd2) begin
        x_d = v; p_d = nz(p_q, v);
      end else begin
        case (aaa)
          3'd1: p_d = (p_q & 8'h3D) | (v & 8'hC0) | (((a_q & v) == 8'd0) ? 8'h02 : 8'h00);
          3'd5: begin y_d = v; p_d = nz(p_q, v); end
          3'd6, 3'd7: begin
            sum = {1'b0, (aaa == 3'd6) ? y_q : x_q} - {1'b0, v};
            p_d = nz(p_q, sum[7:0]); p_d[0] = !sum[8];
          end
          default: ;
        endcase
      end
    end

    if (do_acc) begin
      al_d = addr;
      if (cl.kind == K_STORE) begin
        acc_d[0] = '{addr: addr, wdata: (cc == 2'd1) ? a_q : (cc == 2'd2) ? x_q : y_q,
                     is_write: 1'b1, fetch: 1'b0, last: 1'b0};
        n = 3'd1;
      end else begin
        acc_d[0] = '{addr: addr, wdata: 8'd0, is_write: 1'b0, fetch: 1'b0, last: 1'b1};
        n = 3'd1; st_d = ST_DATA;
      end
    end

    if (irq) begin
      logic [15:0] rpc;
      rpc = brk ? pc_q + 16'd2 : pc_q;
      pc_d = rpc;
      acc_d[0] = '{addr: {8'h01, s_q}, wdata: rpc[15:8], is_write: 1'b1, fetch: 1'b0,
                   last: 1'b0};
      acc_d[1] = '{addr: {8'h01, s_q - 8'd1}, wdata: rpc[7:0], is_write: 1'b1,
                   fetch: 1'b0, last: 1'b0};
      acc_d[2] = '{addr: {8'h01, s_q - 8'd2}, wdata: pushed, is_write: 1'b1,
                   fetch: 1'b0, last: 1'b0};
      acc_d[3] = '{addr: brk ? VEC_BRK : VEC_NMI, wdata: 8'd0, is_write: 1'b0,
                   fetch: 1'b0, last: 1'b1};
      s_d = s_q - 8'd3;
      p_d = p_q | 8'h04;
      al_d = brk ? VEC_BRK : VEC_NMI;
      n = 3'd4; st_d = ST_VLO;
    end else if (n == 3'd0 || !acc_d[2'(n - 3'd1)].last) begin
      // Every path that did not issue its own read ends with an opcode fetch.
      acc_d[2'(n)] = '{addr: pc_d, wdata: 8'd0, is_write: 1'b0, fetch: 1'b1, last: 1'b1};
      n = n + 3'd1;
      st_d = ST_OP;
    end
    n_d = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= 8'd0; x_q <= 8'd0; y_q <= 8'd0; p_q <= FLAGS_RST; s_q <= SP_RST;
      pc_q <= 16'd0; al_q <= VEC_RESET; op_q <= 8'd0; dl_q <= 8'd0; st_q <= ST_VLO;
      n_q <= 3'd0; idx_q <= 2'd0;
    end else if (q_pop_o) begin
      a_q <= a_d; x_q <= x_d; y_q <= y_d; p_q <= p_d; s_q <= s_d;
      pc_q <= pc_d; al_q <= al_d; op_q <= op_d; dl_q <= dl_d; st_q <= st_d;
      n_q <= n_d; idx_q <= 2'd0;
    end else if (busy && !out_stall_i) begin
      if (idx_q == 2'(n_q - 3'd1)) n_q <= 3'd0;
      else idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      for (int i = 0; i < MAXRES; i++) acc_q[i] <= acc_d[i];
    end
  end
endmodule

FILE: hdl/cpu_6502_bus_core.sv
// 6502 bus core: response channel in, bus access channel out.
// Depends on c6502_pkg, c6502_front and c6502_back.
//
// The input channel carries the byte answering the previous read request and
// an NMI line. For each accepted transaction the core emits, in order, up to
// three writes and then exactly one read request marked last_access.
// After reset the outstanding request is a read of 0xFFFC; the first input
// is that byte. Reset asynchronously sets the registers and control state;
// queue entries and the access buffer are not reset. The front end queues
// up to two transactions and raises in_stall_o only when both slots are full.
// The back end executes one transaction in the cycle it takes it and loads
// its accesses into a registered output buffer behind the queue. Throughput
// is one transaction per cycle when each produces one access and out_stall_i
// is low; a transaction with more accesses presents them in turn on the
// output port (up to four for BRK and NMI). When out_stall_i is high the
// current access holds and the queue absorbs further input until it fills.
module cpu_6502_bus_core import c6502_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  read_data_i,
  input  logic        nmi_request_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] bus_address_o,
  output logic [7:0]  bus_write_data_o,
  output logic        bus_is_write_o,
  output logic        opcode_fetch_o,
  output logic        last_access_o
);
  logic  q_valid, q_pop;
  item_t q_head;
  acc_t  acc;

  c6502_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .read_data_i, .nmi_request_i,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_head_o(q_head)
  );

  c6502_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_pop_o(q_pop), .q_head_i(q_head),
    .out_valid_o, .out_stall_i, .out_o(acc)
  );

  assign bus_address_o    = acc.addr;
  assign bus_write_data_o = acc.wdata;
  assign bus_is_write_o   = acc.is_write;
  assign opcode_fetch_o   = acc.fetch;
  assign last_access_o    = acc.last;
endmodule

FILE: hdl/c6502_checker.sv
// Port-level checks for the 6502 bus core, bound to the top level.
// Depends on cpu_6502_bus_core.
module c6502_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  bus_write_data_o,
  input logic        bus_is_write_o,
  input logic        opcode_fetch_o,
  input logic        last_access_o
);
  a_write_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bus_is_write_o |-> !last_access_o && !opcode_fetch_o)
    else $error("write marked last or fetch");
  a_read_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !bus_is_write_o |-> last_access_o && bus_write_data_o == 8'd0)
    else $error("read request not last or carries data");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(bus_is_write_o))
    else $error("stalled access changed");
endmodule

bind cpu_6502_bus_core c6502_checker u_checker (.*);
